FILE: hdl/rgbic_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time PQ curve functions for the
// RGB to ICtCp converter. No dependencies.
package rgbic_pkg;

  localparam int PQ_TABLE_DEPTH = 1024;
  localparam int INPUT_WIDTH    = 16;

  localparam int FIELD_W = 16;
  localparam int PQ_W    = 31;
  localparam int I_W     = 15;
  localparam int C_W     = 16;
  localparam int PROD_W  = 46;
  localparam int MIX_W   = 48;

  localparam int LMS_L_R = 1688;
  localparam int LMS_L_G = 2146;
  localparam int LMS_L_B = 262;
  localparam int LMS_M_R = 683;
  localparam int LMS_M_G = 2951;
  localparam int LMS_M_B = 462;
  localparam int LMS_S_R = 99;
  localparam int LMS_S_G = 309;
  localparam int LMS_S_B = 3688;

  localparam int CT_L = 6610;
  localparam int CT_M = 13613;
  localparam int CT_S = 7003;
  localparam int CP_L = 17933;
  localparam int CP_M = 17390;
  localparam int CP_S = 543;

  localparam longint unsigned Q30    = 64'd1 << 30;
  localparam longint unsigned LN2_Q30 = 64'd744261118;

  typedef struct packed {
    logic en_addr;
    logic en_rom;
    logic en_mul;
    logic en_sum;
  } pq_ctrl_t;

  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((n >> i) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  function automatic int msb_of(longint unsigned x);
    int e;
    e = 0;
    for (int i = 0; i < 63; i++) begin
      if ((x >> (e + 1)) != 0) e++;
    end
    return e;
  endfunction

  function automatic longint log2_q30(longint unsigned x);
    int e;
    longint unsigned m;
    longint unsigned frac;
    e = msb_of(x);
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    frac = 0;
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (Q30 << 1)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (30 - i));
      end
    end
    return longint'(e - 30) * longint'(Q30) + longint'(frac);
  endfunction

  function automatic longint unsigned exp2_frac(longint unsigned g);
    longint unsigned z;
    longint unsigned term;
    longint unsigned sum;
    z = (g * LN2_Q30) >> 30;
    term = Q30;
    sum = Q30;
    for (int n = 1; n <= 16; n++) begin
      term = udiv((term * z) >> 30, longint'(n));
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic longint unsigned exp2_neg(longint unsigned a);
    longint unsigned n;
    longint unsigned f;
    longint unsigned v;
    n = a >> 30;
    f = a & (Q30 - 1);
    v = Q30;
    if (f != 0) begin
      v = exp2_frac(Q30 - f);
      n = n + 1;
    end
    return (n >= 63) ? 64'd0 : (v >> n);
  endfunction

  function automatic longint unsigned div_q30(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q = (n >= d) ? 64'd1 : 64'd0;
    rem = n - q * d;
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned pq_point(longint unsigned k, longint unsigned depth);
    longint unsigned p;
    longint unsigned num;
    longint unsigned den;
    longint unsigned r;
    longint unsigned a;
    longint unsigned b;
    longint ly;
    longint lr;
    p = 0;
    if (k != 0) begin
      ly = log2_q30(k << 30) - log2_q30(depth << 30);
      a = (ly < 0) ? longint'(-ly) : 64'd0;
      p = exp2_neg((a * 64'd2610) >> 14);
    end
    num = 64'd3424 * Q30 + 64'd2413 * 64'd32 * p;
    den = 64'd4096 * Q30 + 64'd2392 * 64'd32 * p;
    r = div_q30(num, den);
    lr = log2_q30(r);
    b = (lr < 0) ? longint'(-lr) : 64'd0;
    return exp2_neg((b * 64'd2523) >> 5);
  endfunction

endpackage

FILE: hdl/rgbic_pq_rom.sv
`timescale 1ns / 1ps
// Constant PQ curve table with two registered read ports.
// Depends on rgbic_pkg for the curve functions.
module rgbic_pq_rom #(
  parameter int DEPTH = rgbic_pkg::PQ_TABLE_DEPTH,
  parameter int AW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [AW-1:0]             addr_lo,
  input  logic [AW-1:0]             addr_hi,
  output logic [rgbic_pkg::PQ_W-1:0] data_lo,
  output logic [rgbic_pkg::PQ_W-1:0] data_hi
);

  typedef logic [rgbic_pkg::PQ_W-1:0] rom_t [DEPTH+1];

  function automatic rom_t build_table();
    rom_t t;
    longint unsigned v;
    longint unsigned prev;
    prev = 0;
    for (int k = 0; k <= DEPTH; k++) begin
      v = rgbic_pkg::pq_point(longint'(k), longint'(DEPTH));
      if (k > 0 && v < prev) v = prev;
      t[k] = rgbic_pkg::PQ_W'(v);
      prev = v;
    end
    return t;
  endfunction

  localparam rom_t TABLE = build_table();

  always_ff @(posedge clk) begin
    if (en) begin
      data_lo <= TABLE[addr_lo];
      data_hi <= TABLE[addr_hi];
    end
  end

endmodule

FILE: hdl/rgbic_pq_interp.sv
`timescale 1ns / 1ps
// One PQ channel: table address, table read, slope multiply, rounding add.
// Depends on rgbic_pkg and rgbic_pq_rom.
module rgbic_pq_interp #(
  parameter int DEPTH = rgbic_pkg::PQ_TABLE_DEPTH,
  parameter int W     = rgbic_pkg::INPUT_WIDTH
) (
  input  logic                       clk,
  input  rgbic_pkg::pq_ctrl_t        ctrl,
  input  logic [W-1:0]               x,
  output logic [rgbic_pkg::PQ_W-1:0] pq
);

  localparam int AW = $clog2(DEPTH + 1);
  localparam int PW = rgbic_pkg::PQ_W;

  logic [W+AW-1:0] pos;
  logic [AW-1:0]   idx_raw;
  logic [AW-1:0]   idx;
  logic [W-1:0]    frac;
  logic [W-1:0]    frac_d;
  logic [PW-1:0]   lo;
  logic [PW-1:0]   hi;
  logic [PW-1:0]   lo_d;
  logic [PW+W-1:0] prod;
  logic [PW+W:0]   prod_rnd;

  assign pos     = (W+AW)'(x) * (W+AW)'(DEPTH);
  assign idx_raw = AW'(pos >> W);

  always_ff @(posedge clk) begin
    if (ctrl.en_addr) begin
      idx  <= (idx_raw >= AW'(DEPTH)) ? AW'(DEPTH - 1) : idx_raw;
      frac <= pos[W-1:0];
    end
    if (ctrl.en_rom) begin
      frac_d <= frac;
    end
    if (ctrl.en_mul) begin
      prod <= (PW+W)'(hi - lo) * (PW+W)'(frac_d);
      lo_d <= lo;
    end
  end

  rgbic_pq_rom #(.DEPTH(DEPTH), .AW(AW)) u_rom (
    .clk     (clk),
    .en      (ctrl.en_rom),
    .addr_lo (idx),
    .addr_hi (idx + AW'(1)),
    .data_lo (lo),
    .data_hi (hi)
  );

  assign prod_rnd = (PW+W+1)'(prod) + ((PW+W+1)'(1) << (W - 1));

  always_ff @(posedge clk) begin
    if (ctrl.en_sum) begin
      pq <= lo_d + PW'(prod_rnd >> W);
    end
  end

endmodule

FILE: hdl/rgb2020_to_ictcp_converter_top.sv
`timescale 1ns / 1ps
// Top level of the BT.2020 RGB to ICtCp (PQ) converter: LMS matrix, three PQ
// channels and the ICtCp mix. Depends on rgbic_pkg and rgbic_pq_interp.
//
//  Channel  | Direction | Payload
//  s_axis   | in        | red_linear, green_linear, blue_linear (16 bits each)
//  m_axis   | out       | intensity (15), tritan_chroma (16), protan_chroma (16)
//
// Seven register stages; a pixel may enter every cycle while the output
// is not stalled. The table read of each PQ channel is one of those
// stages. Reset clears only the stage valid bits.
// Each stage holds its transaction while the stage after it is full and stalled,
// so empty stages keep filling while the output waits.
module rgb2020_to_ictcp_converter_top #(
  parameter int PQ_TABLE_DEPTH = rgbic_pkg::PQ_TABLE_DEPTH,
  parameter int INPUT_WIDTH    = rgbic_pkg::INPUT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // red_linear, green_linear, blue_linear
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // intensity, tritan_chroma, protan_chroma, pad
);

  localparam int W   = INPUT_WIDTH;
  localparam int NS  = 7;
  localparam int SW  = W + 13;
  localparam int PW  = rgbic_pkg::PQ_W;
  localparam int XW  = rgbic_pkg::PROD_W;
  localparam int MW  = rgbic_pkg::MIX_W;
  localparam int FW  = rgbic_pkg::FIELD_W;

  logic [NS-1:0] vld;
  logic [NS-1:0] adv;
  logic [NS-1:0] vin;

  always_comb begin
    adv[NS-1] = !vld[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
    vin[0] = s_axis_tvalid;
    for (int k = 1; k < NS; k++) begin
      vin[k] = vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) vld[k] <= vin[k];
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[NS-1];

  logic [W-1:0]  red;
  logic [W-1:0]  green;
  logic [W-1:0]  blue;
  logic [SW-1:0] l_sum;
  logic [SW-1:0] m_sum;
  logic [SW-1:0] s_sum;
  logic [W-1:0]  l_lin;
  logic [W-1:0]  m_lin;
  logic [W-1:0]  s_lin;

  assign red   = W'(s_axis_tdata[FW-1:0]);
  assign green = W'(s_axis_tdata[2*FW-1:FW]);
  assign blue  = W'(s_axis_tdata[3*FW-1:2*FW]);

  assign l_sum = SW'(rgbic_pkg::LMS_L_R) * SW'(red) + SW'(rgbic_pkg::LMS_L_G) * SW'(green)
               + SW'(rgbic_pkg::LMS_L_B) * SW'(blue) + SW'(2048);
  assign m_sum = SW'(rgbic_pkg::LMS_M_R) * SW'(red) + SW'(rgbic_pkg::LMS_M_G) * SW'(green)
               + SW'(rgbic_pkg::LMS_M_B) * SW'(blue) + SW'(2048);
  assign s_sum = SW'(rgbic_pkg::LMS_S_R) * SW'(red) + SW'(rgbic_pkg::LMS_S_G) * SW'(green)
               + SW'(rgbic_pkg::LMS_S_B) * SW'(blue) + SW'(2048);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      l_lin <= W'(l_sum >> 12);
      m_lin <= W'(m_sum >> 12);
      s_lin <= W'(s_sum >> 12);
    end
  end

  rgbic_pkg::pq_ctrl_t pq_ctrl;
  logic [PW-1:0] l_pq;
  logic [PW-1:0] m_pq;
  logic [PW-1:0] s_pq;

  assign pq_ctrl.en_addr = adv[1];
  assign pq_ctrl.en_rom  = adv[2];
  assign pq_ctrl.en_mul  = adv[3];
  assign pq_ctrl.en_sum  = adv[4];

  rgbic_pq_interp #(.DEPTH(PQ_TABLE_DEPTH), .W(W)) u_pq_l (
    .clk (clk), .ctrl (pq_ctrl), .x (l_lin), .pq (l_pq)
  );
  rgbic_pq_interp #(.DEPTH(PQ_TABLE_DEPTH), .W(W)) u_pq_m (
    .clk (clk), .ctrl (pq_ctrl), .x (m_lin), .pq (m_pq)
  );
  rgbic_pq_interp #(.DEPTH(PQ_TABLE_DEPTH), .W(W)) u_pq_s (
    .clk (clk), .ctrl (pq_ctrl), .x (s_lin), .pq (s_pq)
  );

  logic [XW-1:0] ct_l;
  logic [XW-1:0] ct_m;
  logic [XW-1:0] ct_s;
  logic [XW-1:0] cp_l;
  logic [XW-1:0] cp_m;
  logic [XW-1:0] cp_s;
  logic [PW+1:0] i_sum;
  logic [rgbic_pkg::I_W-1:0] i_mix;

  assign i_sum = (PW+2)'(l_pq) + (PW+2)'(m_pq) + ((PW+2)'(1) << 16);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      ct_l  <= XW'(l_pq) * XW'(rgbic_pkg::CT_L);
      ct_m  <= XW'(m_pq) * XW'(rgbic_pkg::CT_M);
      ct_s  <= XW'(s_pq) * XW'(rgbic_pkg::CT_S);
      cp_l  <= XW'(l_pq) * XW'(rgbic_pkg::CP_L);
      cp_m  <= XW'(m_pq) * XW'(rgbic_pkg::CP_M);
      cp_s  <= XW'(s_pq) * XW'(rgbic_pkg::CP_S);
      i_mix <= rgbic_pkg::I_W'(i_sum >> 17);
    end
  end

  logic signed [MW-1:0] ct_acc;
  logic signed [MW-1:0] cp_acc;
  logic signed [MW-1:0] ct_q;
  logic signed [MW-1:0] cp_q;
  logic [rgbic_pkg::C_W-1:0] ct_sat;
  logic [rgbic_pkg::C_W-1:0] cp_sat;

  assign ct_acc = signed'(MW'(ct_l)) - signed'(MW'(ct_m)) + signed'(MW'(ct_s))
                + (MW'(1) <<< 27);
  assign cp_acc = signed'(MW'(cp_l)) - signed'(MW'(cp_m)) - signed'(MW'(cp_s))
                + (MW'(1) <<< 27);
  assign ct_q = ct_acc >>> 28;
  assign cp_q = cp_acc >>> 28;

  always_comb begin
    if (ct_q > MW'(32767)) begin
      ct_sat = 16'h7FFF;
    end else if (ct_q < -MW'(32768)) begin
      ct_sat = 16'h8000;
    end else begin
      ct_sat = ct_q[rgbic_pkg::C_W-1:0];
    end
    if (cp_q > MW'(32767)) begin
      cp_sat = 16'h7FFF;
    end else if (cp_q < -MW'(32768)) begin
      cp_sat = 16'h8000;
    end else begin
      cp_sat = cp_q[rgbic_pkg::C_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      m_axis_tdata <= {1'b0, cp_sat, ct_sat, i_mix};
    end
  end

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the output is taking transactions");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    ($countones(vld) == NS && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while every stage is full and stalled");

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted transaction did not reach the first stage");

  a_intensity_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[14:0] <= 15'd16384))
    else $error("intensity above 1.0");

endmodule

FILE: dv/rgb2020_to_ictcp_converter_checker.sv
`timescale 1ns / 1ps
// Checker for the RGB to ICtCp converter. It watches both stream channels,
// predicts each pixel with its own PQ curve table and compares the results.
// Depends on rgbic_pkg for the field widths.
module rgb2020_to_ictcp_converter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  output int          errors,
  output int          pending,
  output int          pixels_seen
);

  localparam int DEPTH = 1024;
  localparam int WIDTH = 16;
  localparam longint unsigned ONE = 64'd1 << 30;

  typedef struct packed {
    logic [rgbic_pkg::C_W-1:0] cp;
    logic [rgbic_pkg::C_W-1:0] ct;
    logic [rgbic_pkg::I_W-1:0] i;
  } ictcp_t;

  longint unsigned curve[DEPTH+1];
  ictcp_t pixel_q[$];

  function automatic int top_bit(longint unsigned x);
    int e;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    return e;
  endfunction

  function automatic longint log_base2(longint unsigned x);
    int e;
    longint unsigned m;
    longint unsigned fr;
    e = top_bit(x);
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    fr = 0;
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (ONE << 1)) begin
        m = m >> 1;
        fr = fr | (64'd1 << (30 - i));
      end
    end
    return longint'(e - 30) * longint'(ONE) + longint'(fr);
  endfunction

  function automatic longint unsigned pow2_neg(longint unsigned a);
    longint unsigned n;
    longint unsigned f;
    longint unsigned v;
    longint unsigned z;
    longint unsigned t;
    n = a >> 30;
    f = a & (ONE - 1);
    v = ONE;
    if (f != 0) begin
      z = ((ONE - f) * 64'd744261118) >> 30;
      t = ONE;
      for (int k = 1; k <= 16; k++) begin
        t = ((t * z) >> 30) / k;
        v = v + t;
      end
      n = n + 1;
    end
    return (n >= 63) ? 64'd0 : (v >> n);
  endfunction

  function automatic longint unsigned frac_div(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = n / d;
    r = n - q * d;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned pq_value(longint unsigned k);
    longint unsigned p;
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    longint ly;
    longint lr;
    p = 0;
    if (k != 0) begin
      ly = log_base2(k << 30) - log_base2(longint'(DEPTH) << 30);
      a = (ly < 0) ? longint'(-ly) : 64'd0;
      p = pow2_neg((a * 64'd2610) >> 14);
    end
    r = frac_div(64'd3424 * ONE + 64'd77216 * p, 64'd4096 * ONE + 64'd76544 * p);
    lr = log_base2(r);
    b = (lr < 0) ? longint'(-lr) : 64'd0;
    return pow2_neg((b * 64'd2523) >> 5);
  endfunction

  function automatic longint unsigned pq_interp(longint unsigned x);
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned f;
    pos = x * DEPTH;
    idx = pos >> WIDTH;
    f = pos & ((64'd1 << WIDTH) - 1);
    if (idx >= DEPTH) idx = DEPTH - 1;
    return curve[idx] + (((curve[idx+1] - curve[idx]) * f + (64'd1 << (WIDTH - 1))) >> WIDTH);
  endfunction

  function automatic logic [rgbic_pkg::C_W-1:0] round_q14(longint s);
    longint v;
    v = (s + (64'sd1 << 27)) >>> 28;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[rgbic_pkg::C_W-1:0];
  endfunction

  function automatic ictcp_t convert_pixel(logic [47:0] d);
    longint unsigned r, g, b, l, m, s, lp, mp, sp;
    ictcp_t o;
    r = d[15:0];
    g = d[31:16];
    b = d[47:32];
    l = (1688 * r + 2146 * g + 262 * b + 2048) >> 12;
    m = (683 * r + 2951 * g + 462 * b + 2048) >> 12;
    s = (99 * r + 309 * g + 3688 * b + 2048) >> 12;
    lp = pq_interp(l);
    mp = pq_interp(m);
    sp = pq_interp(s);
    o.i = rgbic_pkg::I_W'((lp + mp + (64'd1 << 16)) >> 17);
    o.ct = round_q14(6610 * longint'(lp) - 13613 * longint'(mp) + 7003 * longint'(sp));
    o.cp = round_q14(17933 * longint'(lp) - 17390 * longint'(mp) - 543 * longint'(sp));
    return o;
  endfunction

  initial begin
    longint unsigned v;
    errors = 0;
    pixels_seen = 0;
    pending = 0;
    for (int k = 0; k <= DEPTH; k++) begin
      v = pq_value(k);
      if (k > 0 && v < curve[k-1]) v = curve[k-1];
      curve[k] = v;
    end
  end

  always @(posedge clk) begin
    ictcp_t want;
    ictcp_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) pixel_q.push_back(convert_pixel(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[46:0];
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          $error("unexpected output transaction %h", m_axis_tdata);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (got.i !== want.i) begin
            $error("intensity: expected %0d, actual %0d", want.i, got.i);
            errors++;
          end
          if (got.ct !== want.ct) begin
            $error("tritan_chroma: expected %0d, actual %0d",
                   $signed(want.ct), $signed(got.ct));
            errors++;
          end
          if (got.cp !== want.cp) begin
            $error("protan_chroma: expected %0d, actual %0d",
                   $signed(want.cp), $signed(got.cp));
            errors++;
          end
        end
      end
      pending = pixel_q.size();
    end
  end
endmodule

FILE: dv/rgb2020_to_ictcp_converter_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the RGB to ICtCp converter: clock, reset, pixel stimulus
// with random gaps and output stalls, and the verdict. Depends on the checker.
module rgb2020_to_ictcp_converter_top_tb;
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  int          errors;
  int          pending;
  int          pixels_seen;
  int          idle_cycles;
  int          sent;
  bit          stall_on;

  rgb2020_to_ictcp_converter_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  rgb2020_to_ictcp_converter_checker checker_i (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .errors(errors), .pending(pending), .pixels_seen(pixels_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  function automatic logic [15:0] channel_value();
    case ($urandom_range(5))
      0: return 16'($urandom_range(255));
      1: return 16'($urandom_range(4095));
      2: return 16'hFFFF - 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : gap_len();
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!stall_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      case ($urandom_range(19))
        0: m_axis_tready <= 1'b0;
        1, 2, 3: m_axis_tready <= 1'b1;
        default: m_axis_tready <= m_axis_tready;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= 5000);
    $display("rgb2020_to_ictcp_converter_top_tb NOT OK");
    $finish;
  end

  initial begin
    logic [15:0] corner[6];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    sent = 0;
    stall_on = 1'b0;
    corner = '{16'h0000, 16'h0001, 16'h0040, 16'h8000, 16'hFFC0, 16'hFFFF};
    repeat (5) @(negedge clk);
    rst = 1'b0;
    for (int k = 0; k < 6; k++) send_pixel(corner[k], corner[k], corner[k], 1'b1);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    send_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    send_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send_pixel(16'h0001, 16'h0000, 16'h0000, 1'b0);
    send_pixel(16'h0000, 16'h0000, 16'h0001, 1'b0);
    send_pixel(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    send_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    stall_on = 1'b1;
    for (int k = 0; k < 1950; k++) begin
      if (k % 300 == 0) stall_on = ~stall_on;
      if (k == 1000) begin
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      send_pixel(channel_value(), channel_value(), channel_value(), !stall_on);
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d pixels (corners, single channels, random mixes) and checked %0d",
             sent, pixels_seen);
    $display("results under random input gaps and output stalls.");
    if (errors == 0 && pending == 0) begin
      $display("rgb2020_to_ictcp_converter_top_tb OK");
    end else begin
      $display("rgb2020_to_ictcp_converter_top_tb NOT OK");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/rgbic_pkg.sv
hdl/rgbic_pq_rom.sv
hdl/rgbic_pq_interp.sv
hdl/rgb2020_to_ictcp_converter_top.sv
dv/rgb2020_to_ictcp_converter_checker.sv
dv/rgb2020_to_ictcp_converter_top_tb.sv
